FILE: src/fir_filter_to_pwm_duty_macros.svh
// ---------------------------------------------------------------------------
// fir_filter_to_pwm_duty assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FIR_FILTER_TO_PWM_DUTY_MACROS_SVH
`define FIR_FILTER_TO_PWM_DUTY_MACROS_SVH

// consequent checked in the same cycle
`define FPWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fpwm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_pkg
// Types, constants and helpers shared by the FIR-to-PWM-duty block.
// ---------------------------------------------------------------------------
package fpwm_pkg;

  // storage depth
  localparam int MAX_TAPS = 64;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // field widths
  localparam int SMP_W    = 12;
  localparam int COEF_W   = 18;
  localparam int CIDX_W   = 6;
  localparam int DUTY_W   = 16;
  localparam int FV_W     = 14;
  localparam int TAPC_W   = 7;
  localparam int MODE_W   = 2;

  // arithmetic
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = COEF_W + SMP_W;
  localparam int ACC_W    = PROD_W + 1 + $clog2(MAX_TAPS);
  localparam int DIV_CONST = 4095;
  localparam int DEN      = DIV_CONST * (1 << FRAC_W);
  localparam int HALF_DEN = DIV_CONST * (1 << (FRAC_W - 1));
  localparam int FV_ROUND = 1 << (FRAC_W - 1);
  localparam int FV_MAX   = (1 << (FV_W - 1)) - 1;
  localparam int FV_MIN   = -(1 << (FV_W - 1));
  localparam int REM_W    = $clog2(DIV_CONST) + DUTY_W;
  // 4097 / 2^24 sits just under 1/4095: the quotient estimate is low by at most one
  localparam int RECIP_MUL = 4097;
  localparam int RECIP_SH  = 24;
  localparam int MUL_A_W  = REM_W + 1;
  localparam int MUL_B_W  = DUTY_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic             RST_FILTER_ENABLE = 1'b0;
  localparam logic [MODE_W-1:0] RST_FILTER_MODE  = 2'd0;
  localparam logic [TAPC_W-1:0] RST_TAP_COUNT    = 7'd64;
  localparam logic [DUTY_W-1:0] RST_PERIOD_TICKS = 16'd120;

  typedef enum logic [1:0] {
    REG_FILTER_ENABLE = 2'd0,
    REG_FILTER_MODE   = 2'd1,
    REG_TAP_COUNT     = 2'd2,
    REG_PERIOD_TICKS  = 2'd3
  } reg_idx_t;

  localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef struct packed {
    logic              filter_enable;
    logic [MODE_W-1:0] filter_mode;
    logic [TAPC_W-1:0] tap_count;
    logic [DUTY_W-1:0] period_ticks;
  } cfg_t;

  // tap memory control from the sequencer
  typedef struct packed {
    logic                     dly_we;
    logic [TAP_AW-1:0]        dly_waddr;
    logic [SMP_W-1:0]         dly_wdata;
    logic                     coef_we;
    logic [TAP_AW-1:0]        coef_waddr;
    logic signed [COEF_W-1:0] coef_wdata;
    logic                     rd_en;
    logic [TAP_AW-1:0]        rd_coef_addr;
    logic [TAP_AW-1:0]        rd_dly_addr;
  } tap_req_t;

  // taps in use: zero acts as one, large values stop at the depth
  function automatic logic [CNT_W-1:0] eff_taps(input logic [TAPC_W-1:0] tc);
    logic [31:0] t;
    t = 32'(tc);
    if (t == 32'd0) t = 32'd1;
    if (t > 32'(MAX_TAPS)) t = 32'(MAX_TAPS);
    return CNT_W'(t);
  endfunction

endpackage

FILE: src/fpwm_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_if
// Valid/ready channels for sample/coefficient beats and duty results.
// ---------------------------------------------------------------------------
interface fpwm_in_if;
  import fpwm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [SMP_W-1:0]         sample_value;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;

  modport source (output valid, cmd, sample_value, coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, sample_value, coef_index, coef_value, output ready);
endinterface

interface fpwm_out_if;
  import fpwm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DUTY_W-1:0]      duty_ticks;
  logic signed [FV_W-1:0] filtered_value;

  modport source (output valid, duty_ticks, filtered_value, input ready);
  modport sink   (input valid, duty_ticks, filtered_value, output ready);
endinterface

FILE: src/fpwm_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_cfg
// APB-style register file: enable, mode, tap count, PWM period.
// ---------------------------------------------------------------------------
module fpwm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpwm_pkg::PADDR_W-1:0] paddr,
  input  logic [fpwm_pkg::PDATA_W-1:0] pwdata,
  output logic [fpwm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output fpwm_pkg::cfg_t               cfg
);
  import fpwm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        REG_FILTER_ENABLE: cfg_nxt.filter_enable = pwdata[0];
        REG_FILTER_MODE:   cfg_nxt.filter_mode   = pwdata[MODE_W-1:0];
        REG_TAP_COUNT:     cfg_nxt.tap_count     = pwdata[TAPC_W-1:0];
        REG_PERIOD_TICKS:  cfg_nxt.period_ticks  = pwdata[DUTY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FILTER_ENABLE: prdata = PDATA_W'(cfg_r.filter_enable);
      REG_FILTER_MODE:   prdata = PDATA_W'(cfg_r.filter_mode);
      REG_TAP_COUNT:     prdata = PDATA_W'(cfg_r.tap_count);
      REG_PERIOD_TICKS:  prdata = PDATA_W'(cfg_r.period_ticks);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable <= RST_FILTER_ENABLE;
      cfg_r.filter_mode   <= RST_FILTER_MODE;
      cfg_r.tap_count     <= RST_TAP_COUNT;
      cfg_r.period_ticks  <= RST_PERIOD_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/fpwm_tap_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_tap_mem
// Delay line and coefficient store, one registered read port each.
// ---------------------------------------------------------------------------
module fpwm_tap_mem (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fpwm_pkg::tap_req_t                 req,
  output logic signed [fpwm_pkg::COEF_W-1:0] coef_rd,
  output logic [fpwm_pkg::SMP_W-1:0]         dly_rd
);
  import fpwm_pkg::*;

  logic [SMP_W-1:0]         dly_mem  [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];

  // per-entry written flags; an unwritten entry reads as zero
  logic [MAX_TAPS-1:0]      dly_vld_r;
  logic [MAX_TAPS-1:0]      coef_vld_r;

  logic [SMP_W-1:0]         dly_q_r;
  logic signed [COEF_W-1:0] coef_q_r;
  logic                     dly_ok_r;
  logic                     coef_ok_r;

  always_ff @(posedge clk) begin
    if (req.dly_we) begin
      dly_mem[req.dly_waddr] <= req.dly_wdata;
    end
    if (req.coef_we) begin
      coef_mem[req.coef_waddr] <= req.coef_wdata;
    end
    if (req.rd_en) begin
      dly_q_r  <= dly_mem[req.rd_dly_addr];
      coef_q_r <= coef_mem[req.rd_coef_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r  <= '0;
      coef_vld_r <= '0;
      dly_ok_r   <= 1'b0;
      coef_ok_r  <= 1'b0;
    end else begin
      if (req.dly_we) begin
        dly_vld_r[req.dly_waddr] <= 1'b1;
      end
      if (req.coef_we) begin
        coef_vld_r[req.coef_waddr] <= 1'b1;
      end
      if (req.rd_en) begin
        dly_ok_r  <= dly_vld_r[req.rd_dly_addr];
        coef_ok_r <= coef_vld_r[req.rd_coef_addr];
      end
    end
  end

  assign dly_rd  = dly_ok_r  ? dly_q_r  : '0;
  assign coef_rd = coef_ok_r ? coef_q_r : '0;

endmodule

FILE: src/fpwm_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_engine
// Sequencer around one shared multiplier: tap MAC, period scaling, then a
// reciprocal divide by 4095 with one correction step to form the duty count.
// ---------------------------------------------------------------------------
module fpwm_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fpwm_pkg::cfg_t                     cfg,
  fpwm_in_if.sink                            in_ch,
  fpwm_out_if.source                         out_ch,
  output fpwm_pkg::tap_req_t                 req,
  input  logic signed [fpwm_pkg::COEF_W-1:0] coef_rd,
  input  logic [fpwm_pkg::SMP_W-1:0]         dly_rd
);
  import fpwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MAC   = 8'b00000010,
    S_PREP  = 8'b00000100,
    S_SCALE = 8'b00001000,
    S_RECIP = 8'b00010000,
    S_BACK  = 8'b00100000,
    S_CORR  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    DSEL_ONE    = 2'd0,
    DSEL_PERIOD = 2'd1,
    DSEL_QUOT   = 2'd2
  } dsel_t;

  state_t                  state_r, state_nxt;
  logic [TAP_AW-1:0]       head_r, head_nxt;
  logic [TAP_AW-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]        taps_r, taps_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    prod_vld_r, prod_vld_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    offset_r, offset_nxt;
  logic [REM_W-1:0]        a_r, a_nxt;
  dsel_t                   dsel_r, dsel_nxt;
  logic signed [FV_W-1:0]  fv_r, fv_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [REM_W-1:0]        qd_r, qd_nxt;
  logic [DUTY_W-1:0]       q_r, q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]       duty_out_r, duty_out_nxt;
  logic signed [FV_W-1:0]  fv_out_r, fv_out_nxt;

  logic                     fire;
  logic                     issue;
  logic                     emit;
  logic                     q_low;
  logic [TAP_AW-1:0]        head_inc;
  logic [TAP_AW-1:0]        idx_dec;
  logic signed [ACC_W:0]    a_w;
  logic signed [ACC_W:0]    fv_sum;
  logic signed [ACC_W:0]    fv_sh;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] prod_w;
  logic [DUTY_W-1:0]        duty_w;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign fire                  = in_ch.valid & in_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.duty_ticks     = duty_out_r;
  assign out_ch.filtered_value = fv_out_r;

  assign head_inc = (head_r == TAP_AW'(MAX_TAPS - 1)) ? '0 : head_r + 1'b1;
  assign idx_dec  = (idx_r == '0) ? TAP_AW'(MAX_TAPS - 1) : idx_r - 1'b1;

  // shared multiplier: coef x sample during MAC, a x period for scaling,
  // then reciprocal estimate and back-multiply for the divide by 4095
  always_comb begin
    op_a = {1'b0, a_r};
    op_b = {1'b0, cfg.period_ticks};
    case (state_r)
      S_MAC: begin
        op_a = {{(MUL_A_W - COEF_W){coef_rd[COEF_W-1]}}, coef_rd};
        op_b = {{(MUL_B_W - SMP_W){1'b0}}, dly_rd};
      end
      S_RECIP: begin
        op_a = {1'b0, rem_r};
        op_b = MUL_B_W'(RECIP_MUL);
      end
      S_BACK: begin
        op_a = MUL_A_W'(q_r);
        op_b = MUL_B_W'(DIV_CONST);
      end
      default: ;
    endcase
  end
  assign prod_w = op_a * op_b;

  // normalized value plus optional half-scale offset, in 2^-16 sample units
  assign a_w    = {acc_r[ACC_W-1], acc_r} + (offset_r ? (ACC_W+1)'(HALF_DEN) : '0);
  assign fv_sum = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(FV_ROUND);
  assign fv_sh  = fv_sum >>> FRAC_W;
  // remainder still holds a whole 4095: the estimate was one short
  assign q_low  = ({1'b0, rem_r} >= ({1'b0, qd_r} + (REM_W+1)'(DIV_CONST)));

  always_comb begin
    case (dsel_r)
      DSEL_ONE:    duty_w = DUTY_W'(1);
      DSEL_PERIOD: duty_w = (cfg.period_ticks == '0) ? DUTY_W'(1) : cfg.period_ticks;
      DSEL_QUOT:   duty_w = (q_r == '0) ? DUTY_W'(1) : q_r;
      default:     duty_w = DUTY_W'(1);
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    taps_nxt     = taps_r;
    acc_nxt      = acc_r;
    offset_nxt   = offset_r;
    a_nxt        = a_r;
    dsel_nxt     = dsel_r;
    fv_nxt       = fv_r;
    rem_nxt      = rem_r;
    qd_nxt       = qd_r;
    q_nxt        = q_r;
    issue        = 1'b0;
    emit         = 1'b0;
    rd_vld_nxt   = 1'b0;
    prod_vld_nxt = rd_vld_r;
    prod_nxt     = rd_vld_r ? prod_w[PROD_W-1:0] : prod_r;

    req              = '0;
    req.dly_waddr    = head_inc;
    req.dly_wdata    = in_ch.sample_value;
    req.coef_waddr   = TAP_AW'(in_ch.coef_index);
    req.coef_wdata   = in_ch.coef_value;
    req.rd_coef_addr = k_r[TAP_AW-1:0];
    req.rd_dly_addr  = idx_r;

    if (prod_vld_r) begin
      acc_nxt = acc_r + $signed({{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r});
    end

    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (in_ch.cmd == CMD_COEF) begin
            req.coef_we = (32'(in_ch.coef_index) < 32'(MAX_TAPS));
          end else if (cfg.filter_enable) begin
            req.dly_we = 1'b1;
            head_nxt   = head_inc;
            idx_nxt    = head_inc;
            k_nxt      = '0;
            taps_nxt   = eff_taps(cfg.tap_count);
            acc_nxt    = '0;
            offset_nxt = (cfg.filter_mode == MODE_HIGHPASS) ||
                         (cfg.filter_mode == MODE_BANDPASS);
            state_nxt  = S_MAC;
          end else begin
            acc_nxt    = $signed(ACC_W'({in_ch.sample_value, {FRAC_W{1'b0}}}));
            offset_nxt = 1'b0;
            state_nxt  = S_PREP;
          end
        end
      end
      S_MAC: begin
        // read -> multiply -> accumulate, one tap issued per cycle
        issue = (k_r < taps_r);
        if (issue) begin
          req.rd_en = 1'b1;
          k_nxt     = k_r + 1'b1;
          idx_nxt   = idx_dec;
        end
        rd_vld_nxt = issue;
        if (!issue && !rd_vld_r && !prod_vld_r) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (fv_sh > FV_MAX) begin
          fv_nxt = FV_W'(FV_MAX);
        end else if (fv_sh < FV_MIN) begin
          fv_nxt = FV_W'(FV_MIN);
        end else begin
          fv_nxt = fv_sh[FV_W-1:0];
        end
        a_nxt = a_w[REM_W-1:0];
        // only 0 < a < 4095*2^16 needs the divide; the rest clamps
        if (a_w <= 0) begin
          dsel_nxt  = DSEL_ONE;
          state_nxt = S_EMIT;
        end else if (a_w >= DEN) begin
          dsel_nxt  = DSEL_PERIOD;
          state_nxt = S_EMIT;
        end else begin
          dsel_nxt  = DSEL_QUOT;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        rem_nxt   = prod_w[REM_W+FRAC_W-1:FRAC_W];
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        q_nxt     = prod_w[RECIP_SH +: DUTY_W];
        state_nxt = S_BACK;
      end
      S_BACK: begin
        qd_nxt    = prod_w[REM_W-1:0];
        state_nxt = S_CORR;
      end
      S_CORR: begin
        if (q_low) begin
          q_nxt = q_r + 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    duty_out_nxt  = emit ? duty_w : duty_out_r;
    fv_out_nxt    = emit ? fv_r : fv_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      rd_vld_r    <= rd_vld_nxt;
      prod_vld_r  <= prod_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    taps_r     <= taps_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    offset_r   <= offset_nxt;
    a_r        <= a_nxt;
    dsel_r     <= dsel_nxt;
    fv_r       <= fv_nxt;
    rem_r      <= rem_nxt;
    qd_r       <= qd_nxt;
    q_r        <= q_nxt;
    duty_out_r <= duty_out_nxt;
    fv_out_r   <= fv_out_nxt;
  end

endmodule

FILE: src/fir_filter_to_pwm_duty.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir_filter_to_pwm_duty
// FIR filter over 12-bit samples whose output is scaled to a PWM duty count.
// ---------------------------------------------------------------------------
// A coefficient write beat gives no result and leaves the input ready. A
// sample beat with filtering on runs from its beat to the next accepted
// beat through: one multiply-accumulate per tap through the single
// shared multiplier (fed by one registered read of each tap memory per
// cycle, then pipeline drain), a prepare step that clamps the filtered
// value and picks the duty path, scaling by the period on the same
// multiplier, a divide by 4095 (reciprocal estimate and back-multiply on
// the multiplier, then a one-step correction), loading the result register
// and the return to idle, which takes the next beat. Pass-through samples
// skip the tap loop; a value that clamps to 1 or to the full period skips
// scaling and divide. The input is not ready while a sample is in work;
// the result sits in an output register, so a pending result only stalls
// the next one at its emit step.
module fir_filter_to_pwm_duty (
  input  logic                         clk,
  input  logic                         rst_n,
  fpwm_in_if.sink                      in_ch,
  fpwm_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpwm_pkg::PADDR_W-1:0] paddr,
  input  logic [fpwm_pkg::PDATA_W-1:0] pwdata,
  output logic [fpwm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import fpwm_pkg::*;

  cfg_t                     cfg;
  tap_req_t                 req;
  logic signed [COEF_W-1:0] coef_rd;
  logic [SMP_W-1:0]         dly_rd;

  fpwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpwm_tap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .coef_rd (coef_rd),
    .dly_rd  (dly_rd)
  );

  fpwm_engine u_eng (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (req),
    .coef_rd (coef_rd),
    .dly_rd  (dly_rd)
  );

endmodule

FILE: src/fpwm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpwm_checker
// Port-level checks on the FIR-to-PWM-duty block, bound to the top level.
// ---------------------------------------------------------------------------
`include "fir_filter_to_pwm_duty_macros.svh"

module fpwm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_cmd,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [fpwm_pkg::DUTY_W-1:0]         duty_ticks,
  input logic signed [fpwm_pkg::FV_W-1:0]    filtered_value
);
  import fpwm_pkg::*;

  // stalled result beat holds
  `FPWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty_ticks) && $stable(filtered_value), "result beat changed while stalled")

  // duty is clamped to at least one tick
  `FPWM_ASSERT_NOW(a_duty_nonzero, out_valid, duty_ticks != '0, "duty_ticks is zero")

  // a sample keeps the block busy
  `FPWM_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (in_cmd == CMD_SAMPLE), !in_ready, "ready right after a sample beat")

  // a coefficient write makes no result and leaves the block ready
  `FPWM_ASSERT_NEXT(a_coef_quiet, in_valid && in_ready && (in_cmd == CMD_COEF) && !out_valid, in_ready && !out_valid, "coefficient write produced a result or stalled")

endmodule

bind fir_filter_to_pwm_duty fpwm_checker u_fpwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_cmd         (in_ch.cmd),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .duty_ticks     (out_ch.duty_ticks),
  .filtered_value (out_ch.filtered_value)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for fir_filter_to_pwm_duty. Sample and coefficient
// beats go in over the valid/ready input channel and registers are set over
// APB while the block is idle. A bit-exact duty/filter predictor queues the
// expected result of each sample beat, and every result beat is compared in
// order. Both channels idle and stall in random bursts.
// ---------------------------------------------------------------------------
module tb_top;
  import fpwm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES       = 9;
  localparam int PHASE_BEATS  = 95;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [DUTY_W-1:0]      duty;
    logic signed [FV_W-1:0] fv;
  } duty_result_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fpwm_in_if  in_ch();
  fpwm_out_if out_ch();

  fir_filter_to_pwm_duty i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register mirror
  logic [SMP_W-1:0]         tap_samples [MAX_TAPS];
  logic signed [COEF_W-1:0] tap_coefs   [MAX_TAPS];
  logic [TAP_AW-1:0]        newest_slot;
  logic                     filt_on;
  logic [MODE_W-1:0]        filt_mode;
  logic [TAPC_W-1:0]        taps_cfg;
  logic [DUTY_W-1:0]        period_cfg;

  duty_result_t duty_expected [$];
  int           mismatch_cnt;
  int           cycle_cnt;
  int           gap_pct;
  int           stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fir_filter_to_pwm_duty test failed");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // bit-exact duty and filtered value for one accepted beat
  function automatic void predict_duty(input logic cmd, input logic [SMP_W-1:0] smp,
                                       input logic [CIDX_W-1:0] ci,
                                       input logic signed [COEF_W-1:0] cv);
    longint       acc;
    longint       num;
    longint       den;
    longint       duty;
    longint       fv;
    int           taps;
    int           slot;
    bit           offs;
    duty_result_t r;
    if (cmd == CMD_COEF) begin
      if (int'(ci) < MAX_TAPS) tap_coefs[ci] = cv;
      return;
    end
    if (filt_on) begin
      taps = int'(taps_cfg);
      if (taps < 1) taps = 1;
      if (taps > MAX_TAPS) taps = MAX_TAPS;
      newest_slot = (int'(newest_slot) >= MAX_TAPS - 1) ? '0 : newest_slot + 1'b1;
      tap_samples[newest_slot] = smp;
      acc = 0;
      slot = int'(newest_slot);
      for (int k = 0; k < taps; k++) begin
        acc += longint'(tap_coefs[k]) * longint'(tap_samples[slot]);
        slot = (slot == 0) ? MAX_TAPS - 1 : slot - 1;
      end
      offs = (filt_mode == MODE_HIGHPASS) || (filt_mode == MODE_BANDPASS);
    end else begin
      acc = longint'(smp) <<< FRAC_W;
      offs = 1'b0;
    end
    fv = (acc + longint'(FV_ROUND)) >>> FRAC_W;
    if (fv > FV_MAX) fv = FV_MAX;
    if (fv < FV_MIN) fv = FV_MIN;
    den = longint'(DIV_CONST) <<< FRAC_W;
    num = longint'(period_cfg) * acc;
    if (offs) num += longint'(period_cfg) * longint'(DIV_CONST) * longint'(FV_ROUND);
    duty = (num < den) ? 0 : num / den;
    if (duty > longint'(period_cfg)) duty = longint'(period_cfg);
    if (duty < 1) duty = 1;
    r.duty = duty[DUTY_W-1:0];
    r.fv   = fv[FV_W-1:0];
    duty_expected.push_back(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    duty_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result duty=%0d fv=%0d",
                                out_ch.duty_ticks, out_ch.filtered_value));
      end else begin
        e = duty_expected.pop_front();
        if (out_ch.duty_ticks !== e.duty || out_ch.filtered_value !== e.fv)
          flag_mismatch($sformatf("expected duty=%0d fv=%0d, got duty=%0d fv=%0d",
                                  e.duty, e.fv, out_ch.duty_ticks,
                                  out_ch.filtered_value));
      end
    end
  end

  // result-side backpressure
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(3);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [SMP_W-1:0] smp,
                           input logic [CIDX_W-1:0] ci,
                           input logic signed [COEF_W-1:0] cv);
    int idle_n;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      idle_n = $urandom_range(1, 4);
      repeat (idle_n) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.cmd          = cmd;
    in_ch.sample_value = smp;
    in_ch.coef_index   = ci;
    in_ch.coef_value   = cv;
    do @(posedge clk); while (!in_ch.ready);
    predict_duty(cmd, smp, ci, cv);
  endtask

  // unused fields carry random bits
  task automatic send_sample(input logic [SMP_W-1:0] smp);
    send_beat(CMD_SAMPLE, smp, CIDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [CIDX_W-1:0] ci, input logic signed [COEF_W-1:0] cv);
    send_beat(CMD_COEF, SMP_W'($urandom), ci, cv);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_FILTER_ENABLE: filt_on    = v[0];
      REG_FILTER_MODE:   filt_mode  = v[MODE_W-1:0];
      REG_TAP_COUNT:     taps_cfg   = v[TAPC_W-1:0];
      REG_PERIOD_TICKS:  period_cfg = v[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drop valid, drain results, then let a trailing coefficient beat finish
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_passthrough();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2048);
    send_coef(6'd5, 18'sd1000);
    send_sample(12'd2047);
    wait_idle();
    // offset must not apply with filtering off
    cfg_write(REG_FILTER_MODE, 32'(MODE_HIGHPASS));
    cfg_write(REG_PERIOD_TICKS, 32'd65535);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd3000);
    wait_idle();
    cfg_write(REG_PERIOD_TICKS, 32'd0);
    send_sample(12'd100);
    wait_idle();
  endtask

  task automatic test_coef_extremes();
    send_coef(6'd0, 18'sh1FFFF);
    send_coef(6'd1, 18'sh20000);
    send_coef(6'd63, -18'sd1);
    wait_idle();
    cfg_write(REG_FILTER_ENABLE, 32'd1);
    cfg_write(REG_FILTER_MODE, 32'(MODE_LOWPASS));
    cfg_write(REG_TAP_COUNT, 32'd1);
    cfg_write(REG_PERIOD_TICKS, 32'd65535);
    send_sample(12'd4095);
    send_sample(12'd1);
    wait_idle();
    // zero taps acts as one, spare mode acts as lowpass
    cfg_write(REG_TAP_COUNT, 32'd0);
    cfg_write(REG_FILTER_MODE, 32'(MODE_SPARE));
    send_sample(12'd0);
    wait_idle();
    // oversize tap count stops at the full depth
    cfg_write(REG_TAP_COUNT, 32'd127);
    cfg_write(REG_FILTER_MODE, 32'(MODE_BANDPASS));
    cfg_write(REG_PERIOD_TICKS, 32'd1);
    send_sample(12'd4095);
    send_sample(12'd0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [TAPC_W-1:0] tc;
    logic [DUTY_W-1:0] per;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      if (p == PHASES - 1) gap_pct = 0;
      case ($urandom_range(7))
        0: tc = 7'd0;
        1: tc = 7'd127;
        2: tc = 7'd64;
        3: tc = 7'd1;
        default: tc = TAPC_W'($urandom_range(2, 64));
      endcase
      case ($urandom_range(5))
        0: per = 16'd0;
        1: per = 16'd65535;
        2: per = 16'd1;
        default: per = DUTY_W'($urandom_range(2, 65534));
      endcase
      cfg_write(REG_FILTER_ENABLE, 32'($urandom_range(3) != 0));
      cfg_write(REG_FILTER_MODE, 32'($urandom_range(3)));
      cfg_write(REG_TAP_COUNT, 32'(tc));
      cfg_write(REG_PERIOD_TICKS, 32'(per));
      // a full set of small positive taps keeps duty off the rails
      if ($urandom_range(1) == 1) begin
        for (int k = 0; k < MAX_TAPS; k++)
          send_coef(CIDX_W'(k), COEF_W'($urandom_range(0, 2048)));
      end
      repeat (PHASE_BEATS) begin
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1) == 1)
            send_coef(CIDX_W'($urandom), COEF_W'($urandom));
          else
            send_coef(CIDX_W'($urandom), COEF_W'(int'($urandom_range(0, 4095)) - 2048));
        end else begin
          send_sample(SMP_W'($urandom));
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_SAMPLE;
    in_ch.sample_value = '0;
    in_ch.coef_index   = '0;
    in_ch.coef_value   = '0;
    mismatch_cnt       = 0;
    cycle_cnt          = 0;
    gap_pct            = 30;
    filt_on            = RST_FILTER_ENABLE;
    filt_mode          = RST_FILTER_MODE;
    taps_cfg           = RST_TAP_COUNT;
    period_cfg         = RST_PERIOD_TICKS;
    newest_slot        = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      tap_samples[k] = '0;
      tap_coefs[k]   = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_passthrough();
    test_coef_extremes();
    test_random_phases();

    if (mismatch_cnt == 0) begin
      $display("fir_filter_to_pwm_duty test passed");
    end else begin
      $display("fir_filter_to_pwm_duty test failed");
    end
    $finish;
  end

endmodule
